// ----- hdl/duart_pkg.sv -----
`timescale 1ns / 1ps

package duart_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    // register numbers on the host bus
    localparam logic [3:0] REG_MODE_A   = 4'd0;
    localparam logic [3:0] REG_STAT_A   = 4'd1;
    localparam logic [3:0] REG_CMD_A    = 4'd2;
    localparam logic [3:0] REG_DATA_A   = 4'd3;
    localparam logic [3:0] REG_IPCR     = 4'd4;
    localparam logic [3:0] REG_ISR_IMR  = 4'd5;
    localparam logic [3:0] REG_MODE_B   = 4'd8;
    localparam logic [3:0] REG_STAT_B   = 4'd9;
    localparam logic [3:0] REG_CMD_B    = 4'd10;
    localparam logic [3:0] REG_DATA_B   = 4'd11;
    localparam logic [3:0] REG_IVR      = 4'd12;
    localparam logic [3:0] REG_IPORT    = 4'd13;
    localparam logic [3:0] REG_START    = 4'd14;
    localparam logic [3:0] REG_STOP     = 4'd15;

    // interrupt status / mask bits
    localparam logic [7:0] IRQ_TX_A     = 8'h01;
    localparam logic [7:0] IRQ_RX_A     = 8'h02;
    localparam logic [7:0] IRQ_CTR      = 8'h08;
    localparam logic [7:0] IRQ_TX_B     = 8'h10;
    localparam logic [7:0] IRQ_RX_B     = 8'h20;

    localparam logic [7:0] STAT_BASE    = 8'h0C;
    localparam logic [7:0] ISR_BASE     = 8'h11;
    localparam logic [7:0] IVR_RESET    = 8'h0F;

    // enable field and command field codes
    localparam logic [1:0] EN_ON        = 2'd1;
    localparam logic [1:0] EN_OFF       = 2'd2;
    localparam logic [3:0] CMD_RST_MR   = 4'd1;
    localparam logic [3:0] CMD_RST_RX   = 4'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_UNIMPL   = 2'd1;
    localparam logic [1:0] CFG_PINS     = 2'd2;

    localparam logic [3:0] PERIOD_RESET = 4'd10;
    localparam logic [7:0] UNIMPL_RESET = 8'hFF;
    localparam logic [6:0] PINS_RESET   = 7'h10;

    typedef struct packed {
        logic [3:0] counter_period;
        logic [7:0] unimpl_value;
        logic [6:0] input_pins;
    } t_cfg;

endpackage

// ----- hdl/duart_apb_regs.sv -----
`timescale 1ns / 1ps

module duart_apb_regs
    import duart_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.counter_period <= PERIOD_RESET;
            r_cfg.unimpl_value   <= UNIMPL_RESET;
            r_cfg.input_pins     <= PINS_RESET;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                CFG_PERIOD: r_cfg.counter_period <= pwdata[3:0];
                CFG_UNIMPL: r_cfg.unimpl_value   <= pwdata[7:0];
                CFG_PINS:   r_cfg.input_pins     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            CFG_PERIOD: prdata = {28'd0, r_cfg.counter_period};
            CFG_UNIMPL: prdata = {24'd0, r_cfg.unimpl_value};
            CFG_PINS:   prdata = {25'd0, r_cfg.input_pins};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/duart_core.sv -----
`timescale 1ns / 1ps

module duart_core
    import duart_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_go,
    input  t_op        i_op,
    input  logic [3:0] i_reg_index,
    input  logic [7:0] i_write_data,
    input  logic       i_rx_channel,
    input  logic [7:0] i_rx_byte,
    output logic [7:0] o_read_data,
    output logic       o_irq_pend,
    output logic       o_tx_valid,
    output logic       o_tx_channel,
    output logic [7:0] o_tx_byte,
    output logic       o_rx_accepted,
    output logic [7:0] o_out_port
);

    logic [7:0] r_mode_a [2];
    logic [7:0] r_mode_b [2];
    logic       r_ptr_a, r_ptr_b;
    logic [1:0] r_rx_en, r_tx_en, r_rx_rdy;
    logic [7:0] r_hold_a, r_hold_b;
    logic [7:0] r_mask, r_vector, r_out_bits;
    logic [3:0] r_ticks;
    logic       r_ctr_rdy, r_ctr_run;

    logic [7:0] n_mode_a [2];
    logic [7:0] n_mode_b [2];
    logic       n_ptr_a, n_ptr_b;
    logic [1:0] n_rx_en, n_tx_en, n_rx_rdy;
    logic [7:0] n_hold_a, n_hold_b;
    logic [7:0] n_mask, n_vector, n_out_bits;
    logic [3:0] n_ticks;
    logic       n_ctr_rdy, n_ctr_run;

    logic [7:0] n_rd, n_tx_byte;
    logic       n_irq, n_txv, n_txc, n_acc;

    logic [1:0] w_ch_bit;
    logic [1:0] w_cmd_bit;
    logic [1:0] w_rx_f, w_tx_f;
    logic [3:0] w_cmd_f;
    logic [3:0] w_tick_inc;

    assign w_ch_bit   = i_rx_channel ? 2'b10 : 2'b01;
    assign w_cmd_bit  = (i_reg_index == REG_CMD_B) ? 2'b10 : 2'b01;
    assign w_rx_f     = i_write_data[1:0];
    assign w_tx_f     = i_write_data[3:2];
    assign w_cmd_f    = i_write_data[7:4];
    assign w_tick_inc = r_ticks + 4'd1;

    always_comb begin
        n_mode_a   = r_mode_a;
        n_mode_b   = r_mode_b;
        n_ptr_a    = r_ptr_a;
        n_ptr_b    = r_ptr_b;
        n_rx_en    = r_rx_en;
        n_tx_en    = r_tx_en;
        n_rx_rdy   = r_rx_rdy;
        n_hold_a   = r_hold_a;
        n_hold_b   = r_hold_b;
        n_mask     = r_mask;
        n_vector   = r_vector;
        n_out_bits = r_out_bits;
        n_ticks    = r_ticks;
        n_ctr_rdy  = r_ctr_rdy;
        n_ctr_run  = r_ctr_run;
        n_rd       = 8'd0;
        n_irq      = 1'b0;
        n_txv      = 1'b0;
        n_txc      = 1'b0;
        n_tx_byte  = 8'd0;
        n_acc      = 1'b0;

        case (i_op)
            OP_READ: begin
                unique case (i_reg_index)
                    REG_MODE_A: begin
                        n_rd    = r_mode_a[r_ptr_a];
                        n_ptr_a = ~r_ptr_a;
                    end
                    REG_MODE_B: begin
                        n_rd    = r_mode_b[r_ptr_b];
                        n_ptr_b = ~r_ptr_b;
                    end
                    REG_STAT_A: n_rd = STAT_BASE | {7'd0, r_rx_rdy[0]};
                    REG_STAT_B: n_rd = STAT_BASE | {7'd0, r_rx_rdy[1]};
                    REG_DATA_A: begin
                        n_rd        = r_hold_a;
                        n_rx_rdy[0] = 1'b0;
                    end
                    REG_DATA_B: begin
                        n_rd        = r_hold_b;
                        n_rx_rdy[1] = 1'b0;
                    end
                    REG_IPCR: n_rd = 8'd0;
                    REG_ISR_IMR: begin
                        n_rd = ISR_BASE
                             | (r_rx_rdy[0] ? IRQ_RX_A : 8'd0)
                             | (r_ctr_rdy   ? IRQ_CTR  : 8'd0)
                             | (r_rx_rdy[1] ? IRQ_RX_B : 8'd0);
                    end
                    REG_IPORT: n_rd = {1'b0, i_cfg.input_pins};
                    REG_START: begin
                        n_ctr_run = 1'b1;
                        n_ctr_rdy = 1'b0;
                        n_ticks   = 4'd0;
                    end
                    default: n_rd = i_cfg.unimpl_value;
                endcase
            end
            OP_WRITE: begin
                unique case (i_reg_index)
                    REG_MODE_A: begin
                        n_mode_a[r_ptr_a] = i_write_data;
                        n_ptr_a           = ~r_ptr_a;
                    end
                    REG_MODE_B: begin
                        n_mode_b[r_ptr_b] = i_write_data;
                        n_ptr_b           = ~r_ptr_b;
                    end
                    REG_CMD_A, REG_CMD_B: begin
                        if (w_rx_f == EN_ON)       n_rx_en = r_rx_en | w_cmd_bit;
                        else if (w_rx_f == EN_OFF) n_rx_en = r_rx_en & ~w_cmd_bit;
                        if (w_tx_f == EN_ON)       n_tx_en = r_tx_en | w_cmd_bit;
                        else if (w_tx_f == EN_OFF) n_tx_en = r_tx_en & ~w_cmd_bit;
                        if (w_cmd_f == CMD_RST_MR) begin
                            if (w_cmd_bit[0]) n_ptr_a = 1'b0;
                            else              n_ptr_b = 1'b0;
                        end else if (w_cmd_f == CMD_RST_RX) begin
                            n_rx_rdy = r_rx_rdy & ~w_cmd_bit;
                        end
                    end
                    REG_DATA_A: begin
                        n_txv     = 1'b1;
                        n_tx_byte = i_write_data;
                        n_irq     = |(r_mask & IRQ_TX_A);
                    end
                    REG_DATA_B: begin
                        n_txv     = 1'b1;
                        n_txc     = 1'b1;
                        n_tx_byte = i_write_data;
                        n_irq     = |(r_mask & IRQ_TX_B);
                    end
                    REG_ISR_IMR: begin
                        n_mask = i_write_data;
                        n_irq  = |(i_write_data & (IRQ_TX_A | IRQ_TX_B))
                               || (|(i_write_data & IRQ_RX_A) && r_rx_rdy[0])
                               || (|(i_write_data & IRQ_RX_B) && r_rx_rdy[1])
                               || (|(i_write_data & IRQ_CTR) && r_ctr_rdy);
                    end
                    REG_IVR:   n_vector   = i_write_data;
                    REG_START: n_out_bits = r_out_bits | i_write_data;
                    REG_STOP:  n_out_bits = r_out_bits & ~i_write_data;
                    default: ;
                endcase
            end
            OP_RX: begin
                if (|(r_rx_en & w_ch_bit) && !(|(r_rx_rdy & w_ch_bit))) begin
                    if (i_rx_channel) n_hold_b = i_rx_byte;
                    else              n_hold_a = i_rx_byte;
                    n_rx_rdy = r_rx_rdy | w_ch_bit;
                    n_acc    = 1'b1;
                    n_irq    = |(r_mask & (i_rx_channel ? IRQ_RX_B : IRQ_RX_A));
                end
            end
            default: begin
                if (r_ctr_run && !r_ctr_rdy) begin
                    n_ticks = w_tick_inc;
                    if (w_tick_inc >= i_cfg.counter_period) begin
                        n_ticks   = 4'd0;
                        n_ctr_rdy = 1'b1;
                        n_irq     = |(r_mask & IRQ_CTR);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_a   <= '{default: 8'd0};
            r_mode_b   <= '{default: 8'd0};
            r_ptr_a    <= 1'b0;
            r_ptr_b    <= 1'b0;
            r_rx_en    <= 2'd0;
            r_tx_en    <= 2'd0;
            r_rx_rdy   <= 2'd0;
            r_hold_a   <= 8'd0;
            r_hold_b   <= 8'd0;
            r_mask     <= 8'd0;
            r_vector   <= IVR_RESET;
            r_out_bits <= 8'd0;
            r_ticks    <= 4'd0;
            r_ctr_rdy  <= 1'b0;
            r_ctr_run  <= 1'b0;
        end else if (i_go) begin
            r_mode_a   <= n_mode_a;
            r_mode_b   <= n_mode_b;
            r_ptr_a    <= n_ptr_a;
            r_ptr_b    <= n_ptr_b;
            r_rx_en    <= n_rx_en;
            r_tx_en    <= n_tx_en;
            r_rx_rdy   <= n_rx_rdy;
            r_hold_a   <= n_hold_a;
            r_hold_b   <= n_hold_b;
            r_mask     <= n_mask;
            r_vector   <= n_vector;
            r_out_bits <= n_out_bits;
            r_ticks    <= n_ticks;
            r_ctr_rdy  <= n_ctr_rdy;
            r_ctr_run  <= n_ctr_run;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            o_read_data   <= n_rd;
            o_irq_pend    <= n_irq;
            o_tx_valid    <= n_txv;
            o_tx_channel  <= n_txc;
            o_tx_byte     <= n_tx_byte;
            o_rx_accepted <= n_acc;
            o_out_port    <= n_out_bits;
        end
    end

endmodule

// ----- hdl/dual_uart_register_block.sv -----
`timescale 1ns / 1ps

// two-channel uart register model: each transaction on the input channel is a
// bus read, bus write, received byte or timer tick, and produces exactly one
// result transaction with read data, interrupt pend, transmit byte, receive
// acceptance and the output port levels. an item passes an input register and
// is applied to the register state once the result register is free or being
// taken, at the same edge that captures its result in the output register; one
// item per cycle is sustained while the result channel does not stall. the input
// side keeps accepting while a result waits, as long as the input stage is empty
// or can move on. configuration (counter period, value of unmodelled registers,
// input pins) sits on an apb-style port at byte addresses 0, 4 and 8; the user
// must write it only while no item is in flight, the block does not enforce this
module dual_uart_register_block
    import duart_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // item input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    input  logic        i_rx_channel,
    input  logic [7:0]  i_rx_byte,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_irq_pend,
    output logic        o_tx_valid,
    output logic        o_tx_channel,
    output logic [7:0]  o_tx_byte,
    output logic        o_rx_accepted,
    output logic [7:0]  o_out_port,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       w_cfg;

    // input stage
    logic       r_s1_valid;
    t_op        r_op;
    logic [3:0] r_reg_index;
    logic [7:0] r_write_data;
    logic       r_rx_channel;
    logic [7:0] r_rx_byte;

    logic       r_out_valid;
    logic       w_go;
    logic       w_in_take;

    // the input stage moves on when the result register is free or being taken
    assign w_go       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_go;
    assign w_in_take  = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take)
                r_s1_valid <= 1'b1;
            else if (w_go)
                r_s1_valid <= 1'b0;

            if (w_go)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // item payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op         <= t_op'(i_op);
            r_reg_index  <= i_reg_index;
            r_write_data <= i_write_data;
            r_rx_channel <= i_rx_channel;
            r_rx_byte    <= i_rx_byte;
        end
    end

    duart_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // register state and result register
    duart_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_go          (w_go),
        .i_op          (r_op),
        .i_reg_index   (r_reg_index),
        .i_write_data  (r_write_data),
        .i_rx_channel  (r_rx_channel),
        .i_rx_byte     (r_rx_byte),
        .o_read_data   (o_read_data),
        .o_irq_pend    (o_irq_pend),
        .o_tx_valid    (o_tx_valid),
        .o_tx_channel  (o_tx_channel),
        .o_tx_byte     (o_tx_byte),
        .o_rx_accepted (o_rx_accepted),
        .o_out_port    (o_out_port)
    );

endmodule
